FILE: src/rhpm_pkg.sv
// Shared types and codes of the rolling hash pattern matcher.
package rhpm_pkg;

	// Operation codes carried on the input channel.
	localparam logic OP_PATTERN = 1'b0;
	localparam logic OP_TEXT    = 1'b1;

	typedef logic [7:0]  byte_t;
	typedef logic [31:0] text_index_t;

	// Per-cycle control broadcast to every cell of the comparator row.
	typedef struct packed {
		logic shift_pattern; // a pattern byte enters cell 0, the rest move one cell on
		logic shift_text;    // a text byte enters cell 0, the window moves one cell on
		logic clear_text;    // a pattern byte empties the text window
	} cell_ctrl_t;

endpackage

FILE: src/rhpm_in_if.sv
// Input channel of the rolling hash pattern matcher: pattern and text bytes.
interface rhpm_in_if;
	logic                 valid;
	logic                 ready;
	logic                 operation;
	logic                 first;
	rhpm_pkg::byte_t      data_byte;

	modport source (output valid, output operation, output first, output data_byte,
		input ready);
	modport sink (input valid, input operation, input first, input data_byte,
		output ready);
endinterface

FILE: src/rhpm_out_if.sv
// Result channel of the rolling hash pattern matcher: one result per text byte.
interface rhpm_out_if;
	logic                  valid;
	logic                  ready;
	logic                  match;
	rhpm_pkg::text_index_t match_position;

	modport source (output valid, output match, output match_position, input ready);
	modport sink (input valid, input match, input match_position, output ready);
endinterface

FILE: src/rhpm_cell.sv
// One comparator cell: a pattern byte, a window byte and its valid bit.
module rhpm_cell (
	input  logic                clk,
	input  logic                arst_n,
	input  rhpm_pkg::cell_ctrl_t ctrl,
	input  logic                active,
	input  rhpm_pkg::byte_t     pat_in,
	input  rhpm_pkg::byte_t     win_in,
	input  logic                win_valid_in,
	output rhpm_pkg::byte_t     pat_out,
	output rhpm_pkg::byte_t     win_out,
	output logic                win_valid_out,
	output logic                ok
);

	rhpm_pkg::byte_t pat_q;
	rhpm_pkg::byte_t win_q;
	logic            win_valid_q;

	always_ff @(posedge clk) begin
		if (ctrl.shift_pattern) begin
			pat_q <= pat_in;
		end
		if (ctrl.shift_text) begin
			win_q <= win_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_valid_q <= 1'b0;
		end else if (ctrl.clear_text) begin
			win_valid_q <= 1'b0;
		end else if (ctrl.shift_text) begin
			win_valid_q <= win_valid_in;
		end
	end

	// The verdict looks at the byte arriving in this cycle, which is what the
	// cell holds once the text byte has been taken.
	assign ok = !active || (win_valid_in && (win_in == pat_q));

	assign pat_out       = pat_q;
	assign win_out       = win_q;
	assign win_valid_out = win_valid_q;

endmodule

FILE: src/rolling_hash_pattern_matcher_core.sv
// Top level of the rolling hash pattern matcher: a row of comparator cells.
//
// The block first takes pattern bytes (operation 0); a byte marked first begins a
// new pattern, and bytes beyond MAX_PATTERN are dropped. Every pattern byte also
// restarts the text. Text bytes (operation 1) then stream in, one per transfer,
// and each one yields exactly one result: match is 1 when the last pattern-length
// text bytes equal the pattern, and match_position then gives the text index at
// which that window starts (modulo 2^32), otherwise 0. An empty pattern never
// matches, and no match is reported until the window has filled since the text
// began. A text byte marked first restarts the text index and the window.
//
// Structure: MAX_PATTERN identical cells form two shift chains, one for the
// pattern (newest pattern byte in cell 0) and one for the text window (newest
// text byte in cell 0). Because the pattern is held in reverse in the same order
// as the window, cell k simply compares its own two bytes, and the block ANDs
// the verdicts of the cells below the pattern length. A rolling hash of the
// window equals the pattern's hash whenever the bytes are equal, so the bytewise
// verdict of the cells alone decides the result and no hash is kept.
//
// Rate: one item per clock cycle while the output register is empty or its result
// is being taken. A text byte's result is formed in the cycle of its transfer and
// held in the output register; the next item is taken while that result waits,
// provided the result is being taken in the same cycle or the output register is
// empty. Results valid rises in the cycle after the input transfer. There is no clearing pass after reset.
module rolling_hash_pattern_matcher_core #(
	parameter int unsigned MAX_PATTERN = 64
) (
	input  logic       clk,
	input  logic       arst_n,
	rhpm_in_if.sink    items,
	rhpm_out_if.source results
);

	localparam int unsigned COUNT_W = $clog2(MAX_PATTERN + 1);

	logic [COUNT_W-1:0]    pattern_count_q;
	rhpm_pkg::text_index_t text_count_q;
	logic                  out_valid_q;
	logic                  out_match_q;
	rhpm_pkg::text_index_t out_position_q;

	logic                  in_xfer;
	logic                  is_pattern;
	logic [COUNT_W-1:0]    count_base;
	logic                  pattern_room;
	rhpm_pkg::text_index_t text_count_next;
	rhpm_pkg::text_index_t window_start;
	rhpm_pkg::cell_ctrl_t  ctrl;
	logic                  hit;

	// Chains between the cells: element k feeds cell k, cell k drives element k+1.
	rhpm_pkg::byte_t       pat_chain       [MAX_PATTERN+1];
	rhpm_pkg::byte_t       win_chain       [MAX_PATTERN+1];
	logic                  win_valid_chain [MAX_PATTERN+1];
	logic [MAX_PATTERN-1:0] cell_ok;
	logic [MAX_PATTERN-1:0] cell_active;

	// A new item is held off only while an untaken result sits in the output register.
	assign items.ready = !out_valid_q || results.ready;
	assign in_xfer     = items.valid && items.ready;
	assign is_pattern  = (items.operation == rhpm_pkg::OP_PATTERN);

	// A first pattern byte counts from an empty pattern.
	assign count_base   = items.first ? '0 : pattern_count_q;
	assign pattern_room = (count_base < COUNT_W'(MAX_PATTERN));

	always_comb begin
		ctrl.shift_pattern = in_xfer && is_pattern && pattern_room;
		ctrl.shift_text    = in_xfer && !is_pattern;
		ctrl.clear_text    = in_xfer && is_pattern;
	end

	// The text index counts text bytes since the text last began.
	assign text_count_next = (items.first ? '0 : text_count_q) + 32'd1;
	assign window_start    = text_count_next - 32'(pattern_count_q);

	// Cell 0 receives the incoming byte; a text byte marked first empties the rest
	// of the window as the new byte enters.
	assign pat_chain[0]       = items.data_byte;
	assign win_chain[0]       = items.data_byte;
	assign win_valid_chain[0] = 1'b1;

	for (genvar k = 0; k < MAX_PATTERN; k++) begin : g_cell
		rhpm_pkg::byte_t cell_pat_out;
		rhpm_pkg::byte_t cell_win_out;
		logic            cell_valid_out;

		assign cell_active[k] = (COUNT_W'(k) < pattern_count_q);

		rhpm_cell u_cell (
			.clk           (clk),
			.arst_n        (arst_n),
			.ctrl          (ctrl),
			.active        (cell_active[k]),
			.pat_in        (pat_chain[k]),
			.win_in        (win_chain[k]),
			.win_valid_in  (win_valid_chain[k]),
			.pat_out       (cell_pat_out),
			.win_out       (cell_win_out),
			.win_valid_out (cell_valid_out),
			.ok            (cell_ok[k])
		);

		assign pat_chain[k+1]       = cell_pat_out;
		assign win_chain[k+1]       = cell_win_out;
		assign win_valid_chain[k+1] = cell_valid_out && !items.first;
	end

	assign hit = (pattern_count_q != '0) && (&cell_ok);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pattern_count_q <= '0;
			text_count_q    <= '0;
		end else if (in_xfer) begin
			if (is_pattern) begin
				pattern_count_q <= pattern_room ? count_base + COUNT_W'(1) : count_base;
				text_count_q    <= '0;
			end else begin
				text_count_q    <= text_count_next;
			end
		end
	end

	// Output register: a text transfer loads a result, a result transfer empties it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctrl.shift_text) begin
			out_valid_q <= 1'b1;
		end else if (results.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.shift_text) begin
			out_match_q    <= hit;
			out_position_q <= hit ? window_start : '0;
		end
	end

	assign results.valid          = out_valid_q;
	assign results.match          = out_match_q;
	assign results.match_position = out_position_q;

endmodule
